### design/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // result field widths are fixed
    localparam int CENTER_W = 40;
    localparam int RADIUS_W = 39;

    // a truncated centre at or beyond 2^FAR_SHIFT forces the radius to full scale
    localparam int FAR_SHIFT = 62;

    localparam int FRONT_STAGES = 5;
    localparam int FBUSY_W      = $clog2(FRONT_STAGES + 1);

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } tcc_qstat_t;

endpackage

`default_nettype wire

### design/tcc_front.sv
`default_nettype none

module tcc_front import tcc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         push,
    output logic [2*COORD_BITS+2:0]      det_a,
    output logic [3*COORD_BITS+2:0]      det_b,
    output logic [3*COORD_BITS+2:0]      det_c,
    output logic [COORD_BITS-1:0]        x1,
    output logic [COORD_BITS-1:0]        y1,
    output logic [FBUSY_W-1:0]           busy
);

    localparam int DW  = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS;
    localparam int SDW = 2 * COORD_BITS + 1;
    localparam int PAW = 2 * COORD_BITS + 2;
    localparam int AW  = 2 * COORD_BITS + 3;
    localparam int PBW = 3 * COORD_BITS + 2;
    localparam int BW  = 3 * COORD_BITS + 3;

    logic [FRONT_STAGES-1:0] v_reg;

    // stage 1: edge vectors and squares
    logic signed [DW-1:0]          s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    logic [SQW-1:0]                s1_sax_reg, s1_say_reg, s1_sbx_reg;
    logic [SQW-1:0]                s1_sby_reg, s1_scx_reg, s1_scy_reg;
    logic signed [COORD_BITS-1:0]  s1_x1_reg, s1_y1_reg;
    // stage 2: squared norms and products for a
    logic signed [DW-1:0]          s2_dx1_reg, s2_dy1_reg, s2_dx2_reg, s2_dy2_reg;
    logic [SQW-1:0]                s2_s0_reg, s2_s1_reg, s2_s2_reg;
    logic signed [PAW-1:0]         s2_pa1_reg, s2_pa2_reg;
    logic signed [COORD_BITS-1:0]  s2_x1_reg, s2_y1_reg;
    // stage 3: norm differences and a
    logic signed [DW-1:0]          s3_dx1_reg, s3_dy1_reg, s3_dx2_reg, s3_dy2_reg;
    logic signed [SDW-1:0]         s3_ds1_reg, s3_ds2_reg;
    logic signed [AW-1:0]          s3_a_reg;
    logic signed [COORD_BITS-1:0]  s3_x1_reg, s3_y1_reg;
    // stage 4: products for b and c
    logic signed [PBW-1:0]         s4_pb1_reg, s4_pb2_reg, s4_pc1_reg, s4_pc2_reg;
    logic signed [AW-1:0]          s4_a_reg;
    logic signed [COORD_BITS-1:0]  s4_x1_reg, s4_y1_reg;
    // stage 5: b and c
    logic signed [BW-1:0]          s5_b_reg, s5_c_reg;
    logic signed [AW-1:0]          s5_a_reg;
    logic signed [COORD_BITS-1:0]  s5_x1_reg, s5_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[FRONT_STAGES-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx1_reg <= DW'(bx) - DW'(ax);
        s1_dy1_reg <= DW'(by) - DW'(ay);
        s1_dx2_reg <= DW'(cx) - DW'(ax);
        s1_dy2_reg <= DW'(cy) - DW'(ay);
        s1_sax_reg <= SQW'(ax) * SQW'(ax);
        s1_say_reg <= SQW'(ay) * SQW'(ay);
        s1_sbx_reg <= SQW'(bx) * SQW'(bx);
        s1_sby_reg <= SQW'(by) * SQW'(by);
        s1_scx_reg <= SQW'(cx) * SQW'(cx);
        s1_scy_reg <= SQW'(cy) * SQW'(cy);
        s1_x1_reg  <= bx;
        s1_y1_reg  <= by;

        s2_dx1_reg <= s1_dx1_reg;
        s2_dy1_reg <= s1_dy1_reg;
        s2_dx2_reg <= s1_dx2_reg;
        s2_dy2_reg <= s1_dy2_reg;
        s2_s0_reg  <= s1_sax_reg + s1_say_reg;
        s2_s1_reg  <= s1_sbx_reg + s1_sby_reg;
        s2_s2_reg  <= s1_scx_reg + s1_scy_reg;
        s2_pa1_reg <= PAW'(s1_dx1_reg) * PAW'(s1_dy2_reg);
        s2_pa2_reg <= PAW'(s1_dx2_reg) * PAW'(s1_dy1_reg);
        s2_x1_reg  <= s1_x1_reg;
        s2_y1_reg  <= s1_y1_reg;

        s3_dx1_reg <= s2_dx1_reg;
        s3_dy1_reg <= s2_dy1_reg;
        s3_dx2_reg <= s2_dx2_reg;
        s3_dy2_reg <= s2_dy2_reg;
        s3_ds1_reg <= $signed(SDW'(s2_s1_reg) - SDW'(s2_s0_reg));
        s3_ds2_reg <= $signed(SDW'(s2_s2_reg) - SDW'(s2_s0_reg));
        s3_a_reg   <= AW'(s2_pa1_reg) - AW'(s2_pa2_reg);
        s3_x1_reg  <= s2_x1_reg;
        s3_y1_reg  <= s2_y1_reg;

        s4_pb1_reg <= PBW'(s3_ds1_reg) * PBW'(s3_dy2_reg);
        s4_pb2_reg <= PBW'(s3_ds2_reg) * PBW'(s3_dy1_reg);
        s4_pc1_reg <= PBW'(s3_ds1_reg) * PBW'(s3_dx2_reg);
        s4_pc2_reg <= PBW'(s3_ds2_reg) * PBW'(s3_dx1_reg);
        s4_a_reg   <= s3_a_reg;
        s4_x1_reg  <= s3_x1_reg;
        s4_y1_reg  <= s3_y1_reg;

        s5_b_reg   <= BW'(s4_pb1_reg) - BW'(s4_pb2_reg);
        s5_c_reg   <= BW'(s4_pc1_reg) - BW'(s4_pc2_reg);
        s5_a_reg   <= s4_a_reg;
        s5_x1_reg  <= s4_x1_reg;
        s5_y1_reg  <= s4_y1_reg;
    end

    // count items in flight so the queue can never overflow
    always_comb
    begin
        busy = '0;
        for (int i = 0; i < FRONT_STAGES; i++)
        begin
            busy = busy + FBUSY_W'(v_reg[i]);
        end
    end

    assign push  = v_reg[FRONT_STAGES-1];
    assign det_a = s5_a_reg;
    assign det_b = s5_b_reg;
    assign det_c = s5_c_reg;
    assign x1    = s5_x1_reg;
    assign y1    = s5_y1_reg;

endmodule

`default_nettype wire

### design/tcc_queue.sv
`default_nettype none

module tcc_queue import tcc_pkg::*; #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output tcc_qstat_t   stat
);

    logic [W-1:0]      mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    assign dout       = mem_reg[rd_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

`default_nettype wire

### design/tcc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage, two lanes sharing the divisor.
module tcc_div import tcc_pkg::*; #(
    parameter int NW  = 59,
    parameter int DVW = 36,
    parameter int SBW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NW-1:0]  nx,
    input  logic [NW-1:0]  ny,
    input  logic [DVW-1:0] dv,
    input  logic [SBW-1:0] side,
    output logic           out_valid,
    output logic [NW-1:0]  qx,
    output logic [NW-1:0]  qy,
    output logic [SBW-1:0] side_out
);

    logic           v_reg    [NW];
    logic [DVW-1:0] d_reg    [NW];
    logic [NW-1:0]  nx_reg   [NW];
    logic [NW-1:0]  ny_reg   [NW];
    logic [DVW-1:0] rx_reg   [NW];
    logic [DVW-1:0] ry_reg   [NW];
    logic [NW-1:0]  qx_reg   [NW];
    logic [NW-1:0]  qy_reg   [NW];
    logic [SBW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic           v_prev;
        logic [DVW-1:0] d_prev, rx_prev, ry_prev, rx_next, ry_next;
        logic [NW-1:0]  nx_prev, ny_prev, qx_prev, qy_prev, qx_next, qy_next;
        logic [SBW-1:0] side_prev;
        logic [DVW:0]   tx, ty;
        logic           gex, gey;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign d_prev    = dv;
            assign nx_prev   = nx;
            assign ny_prev   = ny;
            assign rx_prev   = '0;
            assign ry_prev   = '0;
            assign qx_prev   = '0;
            assign qy_prev   = '0;
            assign side_prev = side;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign d_prev    = d_reg[k-1];
            assign nx_prev   = nx_reg[k-1];
            assign ny_prev   = ny_reg[k-1];
            assign rx_prev   = rx_reg[k-1];
            assign ry_prev   = ry_reg[k-1];
            assign qx_prev   = qx_reg[k-1];
            assign qy_prev   = qy_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            tx      = {rx_prev, nx_prev[NW-1-k]};
            ty      = {ry_prev, ny_prev[NW-1-k]};
            gex     = (tx >= {1'b0, d_prev});
            gey     = (ty >= {1'b0, d_prev});
            rx_next = gex ? DVW'(tx - {1'b0, d_prev}) : tx[DVW-1:0];
            ry_next = gey ? DVW'(ty - {1'b0, d_prev}) : ty[DVW-1:0];
            qx_next = qx_prev;
            qy_next = qy_prev;
            qx_next[NW-1-k] = gex;
            qy_next[NW-1-k] = gey;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= d_prev;
                nx_reg[k]   <= nx_prev;
                ny_reg[k]   <= ny_prev;
                rx_reg[k]   <= rx_next;
                ry_reg[k]   <= ry_next;
                qx_reg[k]   <= qx_next;
                qy_reg[k]   <= qy_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign qx        = qx_reg[NW-1];
    assign qy        = qy_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

`default_nettype wire

### design/tcc_sqrt.sv
`default_nettype none

// Digit-by-digit integer square root, one root bit per stage.
module tcc_sqrt import tcc_pkg::*; #(
    parameter int SW  = 123,
    parameter int SBW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SW-1:0]       sq,
    input  logic [SBW-1:0]      side,
    output logic                out_valid,
    output logic [(SW+1)/2-1:0] root,
    output logic [SBW-1:0]      side_out
);

    localparam int RW = (SW + 1) / 2;
    localparam int SE = 2 * RW;

    logic          v_reg    [RW];
    logic [SE-1:0] s_reg    [RW];
    logic [RW+1:0] r_reg    [RW];
    logic [RW-1:0] q_reg    [RW];
    logic [SBW-1:0] side_reg [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_stage
        logic           v_prev, ge;
        logic [SE-1:0]  s_prev;
        logic [RW+1:0]  r_prev, r_next, t_rem, trial;
        logic [RW-1:0]  q_prev;
        logic [SBW-1:0] side_prev;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign s_prev    = SE'(sq);
            assign r_prev    = '0;
            assign q_prev    = '0;
            assign side_prev = side;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign s_prev    = s_reg[k-1];
            assign r_prev    = r_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            t_rem  = {r_prev[RW-1:0], s_prev[2*(RW-1-k)+1 -: 2]};
            trial  = {q_prev, 2'b01};
            ge     = (t_rem >= trial);
            r_next = ge ? t_rem - trial : t_rem;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k]    <= s_prev;
                r_reg[k]    <= r_next;
                q_reg[k]    <= {q_prev[RW-2:0], ge};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = q_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

`default_nettype wire

### design/triangle_circumcircle_core.sv
// Channel  Direction  Handshake             Payload
// in       into       in_valid / in_stall   ax ay bx by cx cy
// out      out of     out_valid / out_stall center_x center_y radius degenerate saturated
//
// One item per cycle sustained while out_stall is low. The divider has
// NW = 3*COORD_BITS + 3 + FRAC_BITS stages, and the square root has RW stages,
// RW being the root bits of the squared distance.
// Reset clears all valid state and the queue; no clearing pass.
// The front keeps accepting while the output is stalled until the queue is full;
// out_stall freezes the whole back pipeline while an item is held at the output.
`default_nettype none

module triangle_circumcircle_core import tcc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [CENTER_W-1:0]   center_x,
    output logic signed [CENTER_W-1:0]   center_y,
    output logic [RADIUS_W-1:0]          radius,
    output logic                         degenerate,
    output logic                         saturated
);

    localparam int CB   = COORD_BITS;
    localparam int AW   = 2 * CB + 3;
    localparam int BW   = 3 * CB + 3;
    localparam int NW   = BW + FRAC_BITS;
    localparam int DVW  = AW + 1;
    localparam int QW   = AW + 2 * BW + 2 * CB;
    localparam int SB1  = 3 + 2 * CB;
    localparam int SB2  = 2 * CENTER_W + 3;
    localparam int QE   = (NW > CENTER_W + 1) ? NW : CENTER_W + 1;
    localparam int QF   = (NW > FAR_SHIFT + 2) ? NW : FAR_SHIFT + 2;
    localparam int QL   = (NW < FAR_SHIFT) ? NW : FAR_SHIFT;
    localparam int DXW  = ((QL + 1 > CB + FRAC_BITS) ? QL + 1 : CB + FRAC_BITS) + 1;
    localparam int MW   = DXW;
    localparam int H    = (MW + 1) / 2;
    localparam int HW   = MW - H;
    localparam int SQW2 = 2 * MW;
    localparam int SW   = 2 * MW + 1;
    localparam int RW   = (SW + 1) / 2;
    localparam int RE   = (RW > RADIUS_W + 1) ? RW : RADIUS_W + 1;

    localparam logic [QE-1:0] CNEG_LIM = QE'(1) << (CENTER_W - 1);
    localparam logic [QE-1:0] CPOS_LIM = CNEG_LIM - 1'b1;
    localparam logic [QF-1:0] FAR_LIM  = QF'(1) << FAR_SHIFT;
    localparam logic [RE-1:0] RAD_MAX  = (RE'(1) << RADIUS_W) - 1'b1;

    logic en;

    // ---------------- front and queue ----------------
    logic               take, push;
    logic [AW-1:0]      f_a;
    logic [BW-1:0]      f_b, f_c;
    logic [CB-1:0]      f_x1, f_y1;
    logic [FBUSY_W-1:0] f_busy;
    logic [QCNT_W:0]    used;
    logic [QW-1:0]      q_dout;
    tcc_qstat_t         qstat;
    logic               pop;

    assign used     = (QCNT_W + 1)'(qstat.count) + (QCNT_W + 1)'(f_busy);
    assign in_stall = (used >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign take     = in_valid && !in_stall;

    tcc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ax    (ax),
        .ay    (ay),
        .bx    (bx),
        .by    (by),
        .cx    (cx),
        .cy    (cy),
        .push  (push),
        .det_a (f_a),
        .det_b (f_b),
        .det_c (f_c),
        .x1    (f_x1),
        .y1    (f_y1),
        .busy  (f_busy)
    );

    tcc_queue #(.W(QW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   ({f_a, f_b, f_c, f_x1, f_y1}),
        .pop   (pop),
        .dout  (q_dout),
        .stat  (qstat)
    );

    // ---------------- back: divisor and signs ----------------
    logic [AW-1:0] h_a, h_amag;
    logic [BW-1:0] h_b, h_c, h_bmag, h_cmag;
    logic [CB-1:0] h_x1, h_y1;

    assign {h_a, h_b, h_c, h_x1, h_y1} = q_dout;
    assign pop    = en && !qstat.empty;
    assign h_amag = h_a[AW-1] ? ~h_a + 1'b1 : h_a;
    assign h_bmag = h_b[BW-1] ? ~h_b + 1'b1 : h_b;
    assign h_cmag = h_c[BW-1] ? ~h_c + 1'b1 : h_c;

    logic           b0_v_reg;
    logic [DVW-1:0] b0_d_reg;
    logic [NW-1:0]  b0_nx_reg, b0_ny_reg;
    logic [SB1-1:0] b0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b0_v_reg <= !qstat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_d_reg    <= {h_amag, 1'b0};
            b0_nx_reg   <= NW'(h_bmag) << FRAC_BITS;
            b0_ny_reg   <= NW'(h_cmag) << FRAC_BITS;
            b0_side_reg <= {(h_a == '0), h_b[BW-1] ^ h_a[AW-1],
                            ~h_c[BW-1] ^ h_a[AW-1], h_x1, h_y1};
        end
    end

    logic           dv_v;
    logic [NW-1:0]  dv_qx, dv_qy;
    logic [SB1-1:0] dv_side;

    tcc_div #(.NW(NW), .DVW(DVW), .SBW(SB1)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b0_v_reg),
        .nx        (b0_nx_reg),
        .ny        (b0_ny_reg),
        .dv        (b0_d_reg),
        .side      (b0_side_reg),
        .out_valid (dv_v),
        .qx        (dv_qx),
        .qy        (dv_qy),
        .side_out  (dv_side)
    );

    // ---------------- clip centre, measure distance ----------------
    logic                 d_degen, d_xneg, d_yneg;
    logic signed [CB-1:0] d_x1, d_y1;
    logic [QE-1:0]        qxe, qye, limx, limy, vx, vy;
    logic                 satx, saty, far;
    logic [QL:0]          tmx, tmy;

    assign {d_degen, d_xneg, d_yneg, d_x1, d_y1} = dv_side;

    always_comb
    begin
        qxe  = QE'(dv_qx);
        qye  = QE'(dv_qy);
        limx = d_xneg ? CNEG_LIM : CPOS_LIM;
        limy = d_yneg ? CNEG_LIM : CPOS_LIM;
        satx = (qxe > limx);
        saty = (qye > limy);
        vx   = satx ? limx : qxe;
        vy   = saty ? limy : qye;
        far  = (QF'(dv_qx) >= FAR_LIM) || (QF'(dv_qy) >= FAR_LIM);
        tmx  = {1'b0, dv_qx[QL-1:0]};
        tmy  = {1'b0, dv_qy[QL-1:0]};
    end

    logic [5:0]                 pv_reg;
    logic [CENTER_W-1:0]        p1_cx_reg, p1_cy_reg;
    logic                       p1_sat_reg, p1_far_reg, p1_degen_reg;
    logic signed [QL:0]         p1_cvx_reg, p1_cvy_reg;
    logic signed [CB-1:0]       p1_x1_reg, p1_y1_reg;
    logic signed [DXW-1:0]      p2_dx_reg, p2_dy_reg;
    logic [SB2-1:0]             p2_side_reg, p3_side_reg, r1_side_reg;
    logic [SB2-1:0]             r2_side_reg, r3_side_reg;
    logic [MW-1:0]              p3_mx_reg, p3_my_reg;
    logic [2*H-1:0]             r1_llx_reg, r1_lly_reg;
    logic [H+HW-1:0]            r1_lhx_reg, r1_lhy_reg;
    logic [2*HW-1:0]            r1_hhx_reg, r1_hhy_reg;
    logic [SQW2-1:0]            r2_sqx_reg, r2_sqy_reg;
    logic [SW-1:0]              r3_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (en)
        begin
            pv_reg <= {pv_reg[4:0], dv_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_cx_reg    <= d_xneg ? ~vx[CENTER_W-1:0] + 1'b1 : vx[CENTER_W-1:0];
            p1_cy_reg    <= d_yneg ? ~vy[CENTER_W-1:0] + 1'b1 : vy[CENTER_W-1:0];
            p1_sat_reg   <= satx || saty;
            p1_far_reg   <= far;
            p1_degen_reg <= d_degen;
            p1_cvx_reg   <= $signed(d_xneg ? ~tmx + 1'b1 : tmx);
            p1_cvy_reg   <= $signed(d_yneg ? ~tmy + 1'b1 : tmy);
            p1_x1_reg    <= d_x1;
            p1_y1_reg    <= d_y1;

            p2_dx_reg    <= DXW'(p1_cvx_reg) - (DXW'(p1_x1_reg) <<< FRAC_BITS);
            p2_dy_reg    <= DXW'(p1_cvy_reg) - (DXW'(p1_y1_reg) <<< FRAC_BITS);
            p2_side_reg  <= {p1_cx_reg, p1_cy_reg, p1_sat_reg, p1_far_reg, p1_degen_reg};

            p3_mx_reg    <= p2_dx_reg[DXW-1] ? ~p2_dx_reg + 1'b1 : p2_dx_reg;
            p3_my_reg    <= p2_dy_reg[DXW-1] ? ~p2_dy_reg + 1'b1 : p2_dy_reg;
            p3_side_reg  <= p2_side_reg;

            // split each square into half-width partial products
            r1_llx_reg   <= (2*H)'(p3_mx_reg[H-1:0]) * (2*H)'(p3_mx_reg[H-1:0]);
            r1_lly_reg   <= (2*H)'(p3_my_reg[H-1:0]) * (2*H)'(p3_my_reg[H-1:0]);
            r1_lhx_reg   <= (H+HW)'(p3_mx_reg[H-1:0]) * (H+HW)'(p3_mx_reg[MW-1:H]);
            r1_lhy_reg   <= (H+HW)'(p3_my_reg[H-1:0]) * (H+HW)'(p3_my_reg[MW-1:H]);
            r1_hhx_reg   <= (2*HW)'(p3_mx_reg[MW-1:H]) * (2*HW)'(p3_mx_reg[MW-1:H]);
            r1_hhy_reg   <= (2*HW)'(p3_my_reg[MW-1:H]) * (2*HW)'(p3_my_reg[MW-1:H]);
            r1_side_reg  <= p3_side_reg;

            r2_sqx_reg   <= (SQW2'(r1_hhx_reg) << (2*H)) + (SQW2'(r1_lhx_reg) << (H+1))
                            + SQW2'(r1_llx_reg);
            r2_sqy_reg   <= (SQW2'(r1_hhy_reg) << (2*H)) + (SQW2'(r1_lhy_reg) << (H+1))
                            + SQW2'(r1_lly_reg);
            r2_side_reg  <= r1_side_reg;

            r3_s_reg     <= SW'(r2_sqx_reg) + SW'(r2_sqy_reg);
            r3_side_reg  <= r2_side_reg;
        end
    end

    logic           sq_v;
    logic [RW-1:0]  sq_root;
    logic [SB2-1:0] sq_side;

    tcc_sqrt #(.SW(SW), .SBW(SB2)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pv_reg[5]),
        .sq        (r3_s_reg),
        .side      (r3_side_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- output register ----------------
    logic [CENTER_W-1:0] o_cx, o_cy;
    logic                o_sat, o_far, o_degen, rsat;
    logic [RE-1:0]       rext;

    assign {o_cx, o_cy, o_sat, o_far, o_degen} = sq_side;
    assign rext = RE'(sq_root);
    assign rsat = (rext > RAD_MAX);

    logic                out_valid_reg;
    logic [CENTER_W-1:0] cx_reg, cy_reg;
    logic [RADIUS_W-1:0] rad_reg;
    logic                degen_reg, sat_reg;

    assign en = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (o_degen)
            begin
                cx_reg    <= '0;
                cy_reg    <= '0;
                rad_reg   <= '0;
                degen_reg <= 1'b1;
                sat_reg   <= 1'b0;
            end
            else
            begin
                cx_reg    <= o_cx;
                cy_reg    <= o_cy;
                degen_reg <= 1'b0;
                if (o_far || rsat)
                begin
                    rad_reg <= RAD_MAX[RADIUS_W-1:0];
                end
                else
                begin
                    rad_reg <= rext[RADIUS_W-1:0];
                end
                sat_reg   <= o_sat || o_far || rsat;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign radius     = rad_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

endmodule

`default_nettype wire

### design/tcc_checker.sv
`default_nettype none

module tcc_checker import tcc_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [CENTER_W-1:0] center_x,
    input logic signed [CENTER_W-1:0] center_y,
    input logic [RADIUS_W-1:0]        radius,
    input logic                       degenerate,
    input logic                       saturated
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(center_x) && $stable(center_y)
            && $stable(radius) && $stable(degenerate) && $stable(saturated))
        else $error("stalled result item changed");

    // collinear vertices carry no geometry and no clip flag
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> center_x == '0 && center_y == '0 && radius == '0
            && !saturated)
        else $error("degenerate item with nonzero fields");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind triangle_circumcircle_core tcc_checker u_tcc_checker (.*);

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
    import tcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB   = COORD_BITS_DEF;
    localparam int FB   = FRAC_BITS_DEF;
    localparam int RUN_ITEMS = 850;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        coord_t v [6];
    } tri_t;

    typedef struct {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0]        r;
        logic                       deg;
        logic                       sat;
    } circle_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    coord_t ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic signed [CENTER_W-1:0] center_x, center_y;
    logic [RADIUS_W-1:0]        radius;
    logic                       degenerate, saturated;

    bit calm = 1'b0;
    bit feed_done = 1'b0;
    int n_deg = 0, n_sat = 0, n_out = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    triangle_circumcircle_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
        .out_valid(out_valid), .out_stall(out_stall),
        .center_x(center_x), .center_y(center_y), .radius(radius),
        .degenerate(degenerate), .saturated(saturated)
    );

    function automatic logic [63:0] root_floor(logic [127:0] s);
        logic [63:0] r, t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= s)
                r = t;
        end
        return r;
    endfunction

    // clip a truncated centre coordinate magnitude into the 40-bit signed range
    function automatic logic [CENTER_W-1:0] clip_centre(logic [127:0] q, bit neg,
                                                        inout bit sat);
        logic [127:0] lim;
        logic [127:0] v;
        lim = neg ? (128'd1 << 39) : ((128'd1 << 39) - 1);
        v = q;
        if (q > lim)
        begin
            v = lim;
            sat = 1'b1;
        end
        return neg ? CENTER_W'(-v) : CENTER_W'(v);
    endfunction

    function automatic circle_t circumcircle(tri_t t);
        circle_t o;
        logic signed [127:0] x0, y0, x1, y1, x2, y2, s0, s1, s2, da, db, dc;
        logic [127:0] amag, div, qx, qy, bmag, cmag, sq;
        logic signed [127:0] cxv, cyv, ddx, ddy;
        logic [63:0] rad;
        bit aneg, xneg, yneg, sat;
        x0 = t.v[0]; y0 = t.v[1]; x1 = t.v[2]; y1 = t.v[3]; x2 = t.v[4]; y2 = t.v[5];
        s0 = x0 * x0 + y0 * y0;
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        da = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
        db = (s1 - s0) * (y2 - y0) - (s2 - s0) * (y1 - y0);
        dc = (s1 - s0) * (x2 - x0) - (s2 - s0) * (x1 - x0);
        o = '{default: '0};
        if (da == 0)
        begin
            o.deg = 1'b1;
            return o;
        end
        sat  = 1'b0;
        aneg = da < 0;
        amag = aneg ? -da : da;
        div  = amag << 1;
        bmag = (db < 0) ? -db : db;
        cmag = (dc < 0) ? -dc : dc;
        qx = (bmag << FB) / div;
        qy = (cmag << FB) / div;
        xneg = (db < 0) != aneg;
        yneg = !(dc < 0) != aneg;
        if (qy == 0 && dc == 0)
            yneg = 1'b0;
        o.cx = clip_centre(qx, xneg, sat);
        o.cy = clip_centre(qy, yneg, sat);
        if (qx >= (128'd1 << FAR_SHIFT) || qy >= (128'd1 << FAR_SHIFT))
        begin
            rad = (64'd1 << RADIUS_W) - 1;
            sat = 1'b1;
        end
        else
        begin
            cxv = xneg ? -$signed(qx) : $signed(qx);
            cyv = yneg ? -$signed(qy) : $signed(qy);
            ddx = cxv - (x1 <<< FB);
            ddy = cyv - (y1 <<< FB);
            sq  = ddx * ddx + ddy * ddy;
            rad = root_floor(sq);
            if (rad > (64'd1 << RADIUS_W) - 1)
            begin
                rad = (64'd1 << RADIUS_W) - 1;
                sat = 1'b1;
            end
        end
        o.r   = rad[RADIUS_W-1:0];
        o.sat = sat;
        return o;
    endfunction

    class circle_board;
        circle_t pending[$];
        int      errors = 0;

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void note(tri_t t);
            pending.insert(pending.size(), circumcircle(t));
        endfunction

        task check(circle_t got);
            circle_t w;
            if (pending.size() == 0)
            begin
                report("result with nothing outstanding");
                return;
            end
            w = pending.pop_front();
            if (got.cx !== w.cx)
                report($sformatf("center_x %0d want %0d", got.cx, w.cx));
            if (got.cy !== w.cy)
                report($sformatf("center_y %0d want %0d", got.cy, w.cy));
            if (got.r !== w.r)
                report($sformatf("radius %0d want %0d", got.r, w.r));
            if (got.deg !== w.deg)
                report($sformatf("degenerate %0b want %0b", got.deg, w.deg));
            if (got.sat !== w.sat)
                report($sformatf("saturated %0b want %0b", got.sat, w.sat));
        endtask
    endclass

    circle_board board = new();

    task automatic send(tri_t t);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ax <= t.v[0]; ay <= t.v[1]; bx <= t.v[2];
        by <= t.v[3]; cx <= t.v[4]; cy <= t.v[5];
        do
            @(posedge clk);
        while (in_stall);
        board.note(t);
    endtask

    function automatic tri_t make_tri(int a0, int a1, int a2, int a3, int a4, int a5);
        tri_t t;
        t.v[0] = coord_t'(a0); t.v[1] = coord_t'(a1); t.v[2] = coord_t'(a2);
        t.v[3] = coord_t'(a3); t.v[4] = coord_t'(a4); t.v[5] = coord_t'(a5);
        return t;
    endfunction

    function automatic int clamp(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int   k, span, p0, p1, q0, q1;
        case ($urandom_range(3))
            0:
                for (int i = 0; i < 6; i++)
                    t.v[i] = coord_t'($urandom);
            1:
            begin
                span = $urandom_range(64);
                for (int i = 0; i < 6; i++)
                    t.v[i] = coord_t'($urandom_range(2 * span) - span);
            end
            default:
            begin
                // third vertex on or near the line through the first two
                p0 = $urandom_range(65535) - 32768; p1 = $urandom_range(65535) - 32768;
                q0 = p0 + $urandom_range(200) - 100; q1 = p1 + $urandom_range(200) - 100;
                k  = $urandom_range(6) - 3;
                t.v[0] = coord_t'(p0); t.v[1] = coord_t'(p1);
                t.v[2] = coord_t'(clamp(q0)); t.v[3] = coord_t'(clamp(q1));
                t.v[4] = coord_t'(clamp(p0 + k * (q0 - p0) + $urandom_range(2) - 1));
                t.v[5] = coord_t'(clamp(p1 + k * (q1 - p1) + $urandom_range(2) - 1));
            end
        endcase
        return t;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check('{center_x, center_y, radius, degenerate, saturated});
            n_out++;
            if (degenerate) n_deg++;
            if (saturated) n_sat++;
        end
        out_stall <= rst_n && !calm && ($urandom_range(99) < 35);
    end

    initial
    begin
        tri_t sheet[$];
        sheet.insert(sheet.size(), make_tri(0, 0, 0, 0, 0, 0));
        sheet.insert(sheet.size(), make_tri(1, 1, 2, 2, 3, 3));
        sheet.insert(sheet.size(), make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        sheet.insert(sheet.size(), make_tri(32767, 32767, -32768, 32767, 32767, -32768));
        sheet.insert(sheet.size(), make_tri(-32768, -32768, 32767, 32767, 32767, 32766));
        sheet.insert(sheet.size(), make_tri(-32768, -32768, 32767, 32767, 32766, 32767));
        sheet.insert(sheet.size(), make_tri(0, 0, 1, 0, 0, 1));
        sheet.insert(sheet.size(), make_tri(0, 0, 0, 1, 1, 0));
        sheet.insert(sheet.size(), make_tri(-1, 0, 1, 0, 0, 1));
        sheet.insert(sheet.size(), make_tri(-1, 0, 0, 1, 1, 0));
        sheet.insert(sheet.size(), make_tri(-32768, 0, 32767, 0, 0, 1));
        sheet.insert(sheet.size(), make_tri(0, -32768, 0, 32767, 1, 0));
        sheet.insert(sheet.size(), make_tri(-32768, -32767, 32767, 32766, -32767, -32766));
        sheet.insert(sheet.size(), make_tri(-32768, -32768, -32768, -32768, 5, 7));
        sheet.insert(sheet.size(), make_tri(32767, -32768, -32768, 32767, 0, 0));
        sheet.insert(sheet.size(), make_tri(1, 2, 3, 7, 5, 11));
        sheet.insert(sheet.size(), make_tri(-5, -5, 5, -5, 0, 5));
        sheet.insert(sheet.size(), make_tri(3, 0, 0, 4, 0, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (sheet[i])
            send(sheet[i]);
        for (int n = 0; n < RUN_ITEMS; n++)
        begin
            calm = (n >= 300 && n < 420);
            send(random_tri());
        end
        in_valid <= 1'b0;
        calm = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Checked %0d circles from %0d triangles: %0d collinear, %0d clipped.",
                 n_out, sheet.size() + RUN_ITEMS, n_deg, n_sat);
        if (board.errors == 0)
            $display("triangle_circumcircle_core verification clean");
        else
            $display("triangle_circumcircle_core verification failed");
        $finish;
    end

    initial
    begin
        #600us;
        $display("Timed out with %0d circles outstanding.", board.pending.size());
        $display("triangle_circumcircle_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/tcc_pkg.sv
design/tcc_front.sv
design/tcc_queue.sv
design/tcc_div.sv
design/tcc_sqrt.sv
design/triangle_circumcircle_core.sv
design/tcc_checker.sv
verif/tb_top.sv
